@@ rtl/sawl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_pkg
// Shared types and constants of the stop-and-wait ARQ link core: item codes,
// configuration register indexes, controller commands and status.
// ----------------------------------------------------------------------------
package sawl_pkg;

    // Default sizes handed to the top level parameters
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int SENDER_SLOTS_DEF = 16;

    // Field widths
    localparam int ID_W   = 32;
    localparam int LEN_W  = 16;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int CNT_W  = 16;
    localparam int CFG_DW = 16;

    // Protocol constants
    localparam logic [LEN_W-1:0] ACK_LEN    = 16'd16;
    localparam logic [ID_W-1:0]  RESTART_ID = 32'd1;
    localparam logic [CNT_W-1:0] CNT_MAX    = 16'hFFFF;

    // Configuration reset values
    localparam logic [CFG_DW-1:0] WAIT_LIMIT_RST = 16'd10;
    localparam logic [CFG_DW-1:0] LOST_LIMIT_RST = 16'd5;

    // Item command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SUBMIT = 2'd1,
        CMD_RECV   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND_NEW   = 3'd1,
        ACT_RETRANSMIT = 3'd2,
        ACT_SEND_ACK   = 3'd3,
        ACT_ACK_MATCH  = 3'd4,
        ACT_QUEUED     = 3'd5,
        ACT_QUEUE_FULL = 3'd6
    } action_t;

    // Link health level
    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_LOST    = 2'd2
    } level_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WAIT_LIMIT = 1'b0,
        REG_LOST_LIMIT = 1'b1
    } cfg_reg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_SEARCH = 2'd2
    } state_t;

    // One sender table entry
    typedef struct packed {
        logic [IP_W-1:0]   addr;
        logic [PORT_W-1:0] port;
        logic [ID_W-1:0]   last_id;
    } sender_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_clear;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic is_ack;
        logic scan_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ rtl/sawl_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface sawl_in_if;
    import sawl_pkg::*;

    logic              valid;
    logic              ready;
    cmd_t              cmd;
    logic [ID_W-1:0]   msg_id;
    logic [LEN_W-1:0]  pkt_length;
    logic [IP_W-1:0]   src_ip;
    logic [PORT_W-1:0] src_port;

    modport source (
        output valid, cmd, msg_id, pkt_length, src_ip, src_port,
        input  ready
    );

    modport sink (
        input  valid, cmd, msg_id, pkt_length, src_ip, src_port,
        output ready
    );
endinterface

@@ rtl/sawl_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_out_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface sawl_out_if;
    import sawl_pkg::*;

    logic              valid;
    logic              ready;
    action_t           action;
    logic [ID_W-1:0]   out_id;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic              deliver;
    level_t            link_level;
    logic              ack_pending;
    logic              table_full;

    modport source (
        output valid, action, out_id, dest_ip, dest_port, deliver, link_level,
               ack_pending, table_full,
        input  ready
    );

    modport sink (
        input  valid, action, out_id, dest_ip, dest_port, deliver, link_level,
               ack_pending, table_full,
        output ready
    );
endinterface

@@ rtl/sawl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_ctrl
// Item sequencer: takes an item, decodes it, runs the sender table scan for
// received data packets and commits the result once the output is free.
// ----------------------------------------------------------------------------
module sawl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sawl_pkg::ctrl_sts_t  sts,
    output sawl_pkg::ctrl_cmd_t  ctl
);
    import sawl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   need_scan;

    // Received packet that is not the matching ack goes through the table
    assign need_scan = (sts.cmd == CMD_RECV) && !sts.is_ack;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (need_scan)
                begin
                    state_next = ST_SEARCH;
                end
                else if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (sts.scan_done && sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        ctl.capture    = 1'b0;
        ctl.scan_clear = 1'b0;
        ctl.scan_step  = 1'b0;
        ctl.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            ST_DECODE:
            begin
                ctl.scan_clear = need_scan;
                ctl.commit     = !need_scan && sts.out_free;
            end
            ST_SEARCH:
            begin
                ctl.scan_step = !sts.scan_done;
                ctl.commit    = sts.scan_done && sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A commit never lands while the table scan is still stepping
    a_commit_not_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.commit && ctl.scan_step))
        else $error("commit and scan step together");

    // Scanning always follows a decode that asked for it
    a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && $past(state_reg) != ST_SEARCH)
            |-> $past(ctl.scan_clear))
        else $error("search entered without clearing the scan");

    // A new item is only taken after the previous one committed
    a_accept_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.capture && $past(state_reg) != ST_IDLE) |-> $past(ctl.commit))
        else $error("item taken before previous commit");
`endif
endmodule

@@ rtl/sawl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_dp
// Datapath: item registers, link state and counters, pending id FIFO,
// sender table memory with its scan pipeline, and the output register.
// ----------------------------------------------------------------------------
module sawl_dp #(
    parameter int QUEUE_DEPTH  = sawl_pkg::QUEUE_DEPTH_DEF,
    parameter int SENDER_SLOTS = sawl_pkg::SENDER_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  sawl_pkg::cfg_reg_t                cfg_addr,
    input  logic [sawl_pkg::CFG_DW-1:0]       cfg_data,
    // item fields
    input  sawl_pkg::cmd_t                    in_cmd,
    input  logic [sawl_pkg::ID_W-1:0]         in_msg_id,
    input  logic [sawl_pkg::LEN_W-1:0]        in_pkt_length,
    input  logic [sawl_pkg::IP_W-1:0]         in_src_ip,
    input  logic [sawl_pkg::PORT_W-1:0]       in_src_port,
    // result fields
    output logic                              out_valid,
    input  logic                              out_ready,
    output sawl_pkg::action_t                 out_action,
    output logic [sawl_pkg::ID_W-1:0]         out_id,
    output logic [sawl_pkg::IP_W-1:0]         out_dest_ip,
    output logic [sawl_pkg::PORT_W-1:0]       out_dest_port,
    output logic                              out_deliver,
    output sawl_pkg::level_t                  out_link_level,
    output logic                              out_ack_pending,
    output logic                              out_table_full,
    // controller link
    input  sawl_pkg::ctrl_cmd_t               ctl,
    output sawl_pkg::ctrl_sts_t               sts
);
    import sawl_pkg::*;

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int TSW = QCW + 1;
    localparam int SIW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
    localparam int SCW = $clog2(SENDER_SLOTS + 1);

    // Captured item
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PORT_W-1:0] port_reg;

    // Configuration
    logic [CFG_DW-1:0] wait_limit_reg;
    logic [CFG_DW-1:0] lost_limit_reg;

    // Link state
    logic              awaiting_reg,  awaiting_next;
    logic [ID_W-1:0]   last_sent_reg, last_sent_next;
    logic [CNT_W-1:0]  wait_cnt_reg,  wait_cnt_next;
    logic [CNT_W-1:0]  retry_cnt_reg, retry_cnt_next;
    level_t            health_reg,    health_next;
    logic [QIW-1:0]    head_reg,      head_next;
    logic [QCW-1:0]    count_reg,     count_next;

    // Pending FIFO
    logic [ID_W-1:0]   fifo_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]   fifo_rd_reg;
    logic              fifo_we;
    logic [TSW-1:0]    tail_sum;
    logic [TSW-1:0]    tail_wrap;
    logic [QIW-1:0]    head_inc;

    // Sender table and scan
    sender_t           sender_mem [SENDER_SLOTS];
    logic [SENDER_SLOTS-1:0] sender_valid_reg;
    sender_t           tbl_rd_reg;
    logic [SCW-1:0]    scan_idx_reg;
    logic [SIW-1:0]    issue_idx;
    logic              scan_issue;
    logic [SIW-1:0]    pipe_idx_reg;
    logic              pipe_vld_reg;
    logic              free_found_reg;
    logic [SIW-1:0]    free_idx_reg;
    logic              hit;
    logic              deliver_hit;
    logic              pkt_commit;
    logic              tbl_we;
    logic [SIW-1:0]    tbl_wa;

    // Tick arithmetic
    logic [CNT_W-1:0]  wait_inc;
    logic [CNT_W-1:0]  retry_inc;

    // Result
    logic              is_ack;
    logic              pkt_deliver;
    logic              pkt_full;
    action_t           res_action;
    logic [ID_W-1:0]   res_id;
    logic [IP_W-1:0]   res_ip;
    logic [PORT_W-1:0] res_port;
    logic              res_deliver;
    logic              res_full;

    // Output register
    logic              out_valid_reg;
    action_t           out_action_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [IP_W-1:0]   out_ip_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic              out_deliver_reg;
    level_t            out_level_reg;
    logic              out_wait_reg;
    logic              out_full_reg;
    logic              out_free;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= in_cmd;
            id_reg   <= in_msg_id;
            len_reg  <= in_pkt_length;
            ip_reg   <= in_src_ip;
            port_reg <= in_src_port;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg <= WAIT_LIMIT_RST;
            lost_limit_reg <= LOST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WAIT_LIMIT: wait_limit_reg <= cfg_data;
                REG_LOST_LIMIT: lost_limit_reg <= cfg_data;
                default:        wait_limit_reg <= wait_limit_reg;
            endcase
        end
    end

    // FIFO addressing
    assign head_inc  = (head_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QIW'(1);
    assign tail_sum  = TSW'(head_reg) + TSW'(count_reg);
    assign tail_wrap = (tail_sum >= TSW'(QUEUE_DEPTH)) ? tail_sum - TSW'(QUEUE_DEPTH)
                                                      : tail_sum;

    // Pending FIFO memory, head read every cycle
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_wrap[QIW-1:0]] <= id_reg;
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    // Scan issue: one slot read per step
    assign issue_idx  = scan_idx_reg[SIW-1:0];
    assign scan_issue = ctl.scan_step && (scan_idx_reg < SCW'(SENDER_SLOTS));

    // Compare stage
    assign hit = pipe_vld_reg && sender_valid_reg[pipe_idx_reg]
                 && (tbl_rd_reg.addr == ip_reg) && (tbl_rd_reg.port == port_reg);
    assign deliver_hit = (id_reg > tbl_rd_reg.last_id) || (id_reg == RESTART_ID);

    // Filter decision after the scan
    assign is_ack      = (id_reg == last_sent_reg) && (len_reg == ACK_LEN);
    assign pkt_deliver = hit ? deliver_hit : 1'b1;
    assign pkt_full    = !hit && !free_found_reg;
    assign pkt_commit  = ctl.commit && (cmd_reg == CMD_RECV) && !is_ack;
    assign tbl_we      = pkt_commit && (hit ? deliver_hit : free_found_reg);
    assign tbl_wa      = hit ? pipe_idx_reg : free_idx_reg;

    // Sender table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            sender_mem[tbl_wa] <= '{addr: ip_reg, port: port_reg, last_id: id_reg};
        end
        if (scan_issue)
        begin
            tbl_rd_reg <= sender_mem[issue_idx];
        end
    end

    // Scan payload: slot index in the compare stage, first free slot
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            pipe_idx_reg <= issue_idx;
            if (!sender_valid_reg[issue_idx] && !free_found_reg)
            begin
                free_idx_reg <= issue_idx;
            end
        end
    end

    // Scan control and slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg     <= '0;
            pipe_vld_reg     <= 1'b0;
            free_found_reg   <= 1'b0;
            sender_valid_reg <= '0;
        end
        else
        begin
            if (ctl.scan_clear)
            begin
                scan_idx_reg   <= '0;
                pipe_vld_reg   <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                pipe_vld_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + SCW'(1);
                    if (!sender_valid_reg[issue_idx])
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
            if (tbl_we && !hit)
            begin
                sender_valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // Saturating counters for the tick path
    assign wait_inc  = (wait_cnt_reg == CNT_MAX) ? wait_cnt_reg : wait_cnt_reg + CNT_W'(1);
    assign retry_inc = (retry_cnt_reg == CNT_MAX) ? retry_cnt_reg : retry_cnt_reg + CNT_W'(1);

    // Item result and next link state
    always_comb
    begin
        awaiting_next  = awaiting_reg;
        last_sent_next = last_sent_reg;
        wait_cnt_next  = wait_cnt_reg;
        retry_cnt_next = retry_cnt_reg;
        health_next    = health_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fifo_we        = 1'b0;
        res_action     = ACT_NONE;
        res_id         = '0;
        res_ip         = '0;
        res_port       = '0;
        res_deliver    = 1'b0;
        res_full       = 1'b0;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (!awaiting_reg && (count_reg != '0))
                begin
                    last_sent_next = fifo_rd_reg;
                    head_next      = head_inc;
                    count_next     = count_reg - QCW'(1);
                    wait_cnt_next  = '0;
                    retry_cnt_next = '0;
                    awaiting_next  = 1'b1;
                    res_action     = ACT_SEND_NEW;
                    res_id         = fifo_rd_reg;
                end
                else if (awaiting_reg)
                begin
                    wait_cnt_next = wait_inc;
                    if (wait_inc > wait_limit_reg)
                    begin
                        wait_cnt_next  = '0;
                        retry_cnt_next = retry_inc;
                        health_next    = (retry_inc > lost_limit_reg) ? LVL_LOST
                                                                      : LVL_WARNING;
                        res_action     = ACT_RETRANSMIT;
                        res_id         = last_sent_reg;
                    end
                end
            end
            CMD_SUBMIT:
            begin
                res_id = id_reg;
                if (count_reg < QCW'(QUEUE_DEPTH))
                begin
                    fifo_we    = ctl.commit;
                    count_next = count_reg + QCW'(1);
                    res_action = ACT_QUEUED;
                end
                else
                begin
                    res_action = ACT_QUEUE_FULL;
                end
            end
            CMD_RECV:
            begin
                res_id = id_reg;
                if (is_ack)
                begin
                    awaiting_next = 1'b0;
                    health_next   = LVL_NORMAL;
                    res_action    = ACT_ACK_MATCH;
                end
                else
                begin
                    res_action  = ACT_SEND_ACK;
                    res_ip      = ip_reg;
                    res_port    = port_reg;
                    res_deliver = pkt_deliver;
                    res_full    = pkt_full;
                end
            end
            default:
            begin
                res_action = ACT_NONE;
            end
        endcase
    end

    // Link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            last_sent_reg <= '0;
            wait_cnt_reg  <= '0;
            retry_cnt_reg <= '0;
            health_reg    <= LVL_NORMAL;
            head_reg      <= '0;
            count_reg     <= '0;
        end
        else if (ctl.commit)
        begin
            awaiting_reg  <= awaiting_next;
            last_sent_reg <= last_sent_next;
            wait_cnt_reg  <= wait_cnt_next;
            retry_cnt_reg <= retry_cnt_next;
            health_reg    <= health_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_action_reg  <= res_action;
            out_id_reg      <= res_id;
            out_ip_reg      <= res_ip;
            out_port_reg    <= res_port;
            out_deliver_reg <= res_deliver;
            out_level_reg   <= health_next;
            out_wait_reg    <= awaiting_next;
            out_full_reg    <= res_full;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_action      = out_action_reg;
    assign out_id          = out_id_reg;
    assign out_dest_ip     = out_ip_reg;
    assign out_dest_port   = out_port_reg;
    assign out_deliver     = out_deliver_reg;
    assign out_link_level  = out_level_reg;
    assign out_ack_pending = out_wait_reg;
    assign out_table_full  = out_full_reg;

    // Status to the controller
    assign sts.cmd       = cmd_reg;
    assign sts.is_ack    = is_ack;
    assign sts.scan_done = hit || (pipe_vld_reg && (pipe_idx_reg == SIW'(SENDER_SLOTS - 1)));
    assign sts.out_free  = out_free;

`ifndef SYNTHESIS
    // Results never overwrite one that is still waiting
    a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || out_ready))
        else $error("commit into an occupied output register");

    // A data packet commits only once its table scan has finished
    a_pkt_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_commit |-> sts.scan_done)
        else $error("packet committed before scan finished");

    // The output only turns valid on a commit
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.commit))
        else $error("output valid without commit");

    // FIFO fill never passes its depth
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QUEUE_DEPTH))
        else $error("pending FIFO overfilled");
`endif
endmodule

@@ rtl/stop_and_wait_arq_link_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_link_core
// Stop-and-wait ARQ controller with pending id FIFO, ack timeout and
// retransmission, per-sender duplicate filter and link health level.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per valid/ready handshake: a service tick, a message
//   submission or a received packet. rsp returns exactly one result item for
//   each accepted item, in order. cfg_we/cfg_addr/cfg_data write wait_limit
//   and lost_limit; write them only while the core is idle.
//   Ticks, submissions and matching acks are committed from the decode
//   state; a received data packet first runs the one-slot-per-cycle scan
//   of the sender table memory, which ends at the first matching sender
//   or after the last slot. One item is in work at a time: a new item is
//   accepted only after the previous result is committed.
//   The result sits in an output register, so the next item is accepted
//   while rsp waits; if rsp.ready stays low, the following result is held
//   back and req stalls behind it.
//   Reset: link idle, level normal, FIFO empty, all sender slots free,
//   wait_limit 10, lost_limit 5. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_link_core #(
    parameter int QUEUE_DEPTH  = sawl_pkg::QUEUE_DEPTH_DEF,
    parameter int SENDER_SLOTS = sawl_pkg::SENDER_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  sawl_pkg::cfg_reg_t          cfg_addr,
    input  logic [sawl_pkg::CFG_DW-1:0] cfg_data,
    sawl_in_if.sink                     req,
    sawl_out_if.source                  rsp
);
    import sawl_pkg::*;

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;
    logic      in_ready;

    assign req.ready = in_ready;

    // Sequencer
    sawl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Datapath
    sawl_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .SENDER_SLOTS (SENDER_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .in_cmd          (req.cmd),
        .in_msg_id       (req.msg_id),
        .in_pkt_length   (req.pkt_length),
        .in_src_ip       (req.src_ip),
        .in_src_port     (req.src_port),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_action      (rsp.action),
        .out_id          (rsp.out_id),
        .out_dest_ip     (rsp.dest_ip),
        .out_dest_port   (rsp.dest_port),
        .out_deliver     (rsp.deliver),
        .out_link_level  (rsp.link_level),
        .out_ack_pending (rsp.ack_pending),
        .out_table_full  (rsp.table_full),
        .ctl             (ctl),
        .sts             (sts)
    );
endmodule

@@ dv/tb_stop_and_wait_arq_link_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_link_core
// Self-checking bench for the stop-and-wait ARQ link core. A short directed
// table runs first, with hand-written results where they are obvious. Then
// several phases of random traffic follow, each under its own timeout and
// lost limits, with one long hold-off on the result side. All other results
// are checked against an in-bench model of the link state, pending FIFO and
// sender table.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_link_core;
    import sawl_pkg::*;

    localparam int QD           = QUEUE_DEPTH_DEF;
    localparam int NSLOT        = SENDER_SLOTS_DEF;
    localparam int NPOOL        = 20;
    localparam int NPHASE       = 6;
    localparam int PHASE_ITEMS  = 180;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS  = 10;

    // Timeout / lost limits per random phase, extremes included
    localparam logic [CFG_DW-1:0] WAIT_SET [NPHASE] = '{16'd10, 16'd0, 16'hFFFF,
                                                         16'd2, 16'd1, 16'd3};
    localparam logic [CFG_DW-1:0] LOST_SET [NPHASE] = '{16'd5, 16'd0, 16'hFFFF,
                                                         16'd1, 16'hFFFF, 16'd0};

    typedef struct packed {
        cmd_t              cmd;
        logic [ID_W-1:0]   msg_id;
        logic [LEN_W-1:0]  len;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } link_item_t;

    typedef struct packed {
        action_t           action;
        logic [ID_W-1:0]   id;
        logic [IP_W-1:0]   dip;
        logic [PORT_W-1:0] dport;
        logic              deliver;
        level_t            level;
        logic              waiting;
        logic              full;
    } link_result_t;

    typedef struct {
        link_item_t   item;
        int           reps;
        bit           typed;
        link_result_t res;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_reg_t          cfg_addr;
    logic [CFG_DW-1:0] cfg_data;

    sawl_in_if  req_if ();
    sawl_out_if rsp_if ();

    stop_and_wait_arq_link_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .req      (req_if),
        .rsp      (rsp_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Model state: link, pending FIFO, sender table, limits
    logic              link_busy;
    logic [ID_W-1:0]   sent_id;
    logic [CNT_W-1:0]  tick_cnt;
    logic [CNT_W-1:0]  retx_cnt;
    level_t            level;
    logic [ID_W-1:0]   fifo_ids [QD];
    int                fifo_head;
    int                fifo_cnt;
    logic              slot_used [NSLOT];
    logic [IP_W-1:0]   slot_ip   [NSLOT];
    logic [PORT_W-1:0] slot_port [NSLOT];
    logic [ID_W-1:0]   slot_id   [NSLOT];
    logic [CFG_DW-1:0] lim_wait;
    logic [CFG_DW-1:0] lim_lost;

    // Traffic sources for received packets
    logic [IP_W-1:0]   pool_ip   [NPOOL];
    logic [PORT_W-1:0] pool_port [NPOOL];
    logic [ID_W-1:0]   pool_next [NPOOL];

    link_result_t exp_q [$];
    plan_row_t    plan [$];

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic stall_rsp   = 1'b0;
    logic hold_go     = 1'b0;

    int n_errors   = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_retx     = 0;
    int n_lost     = 0;
    int n_dup      = 0;
    int n_overflow = 0;

    // Next result of the link for one item; updates the model state
    function automatic link_result_t predict_result(link_item_t it);
        link_result_t r;
        int           hit;
        int           free_slot;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        case (it.cmd)
            CMD_TICK:
            begin
                if (!link_busy && fifo_cnt > 0)
                begin
                    sent_id   = fifo_ids[fifo_head];
                    fifo_head = (fifo_head + 1) % QD;
                    fifo_cnt  = fifo_cnt - 1;
                    tick_cnt  = '0;
                    retx_cnt  = '0;
                    link_busy = 1'b1;
                    r.action  = ACT_SEND_NEW;
                    r.id      = sent_id;
                end
                else if (link_busy)
                begin
                    if (tick_cnt != CNT_MAX)
                        tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt > lim_wait)
                    begin
                        tick_cnt = '0;
                        level    = LVL_WARNING;
                        if (retx_cnt != CNT_MAX)
                            retx_cnt = retx_cnt + 1'b1;
                        if (retx_cnt > lim_lost)
                            level = LVL_LOST;
                        r.action = ACT_RETRANSMIT;
                        r.id     = sent_id;
                    end
                end
            end
            CMD_SUBMIT:
            begin
                r.id = it.msg_id;
                if (fifo_cnt < QD)
                begin
                    fifo_ids[(fifo_head + fifo_cnt) % QD] = it.msg_id;
                    fifo_cnt = fifo_cnt + 1;
                    r.action = ACT_QUEUED;
                end
                else
                    r.action = ACT_QUEUE_FULL;
            end
            CMD_RECV:
            begin
                r.id = it.msg_id;
                if (it.msg_id == sent_id && it.len == ACK_LEN)
                begin
                    link_busy = 1'b0;
                    level     = LVL_NORMAL;
                    r.action  = ACT_ACK_MATCH;
                end
                else
                begin
                    r.action = ACT_SEND_ACK;
                    r.dip    = it.ip;
                    r.dport  = it.port;
                    // duplicate filter over the sender table
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (slot_used[i])
                        begin
                            if (hit < 0 && slot_ip[i] == it.ip && slot_port[i] == it.port)
                                hit = i;
                        end
                        else if (free_slot < 0)
                            free_slot = i;
                    end
                    if (hit >= 0)
                    begin
                        if (it.msg_id > slot_id[hit] || it.msg_id == RESTART_ID)
                        begin
                            slot_id[hit] = it.msg_id;
                            r.deliver    = 1'b1;
                        end
                    end
                    else
                    begin
                        r.deliver = 1'b1;
                        if (free_slot >= 0)
                        begin
                            slot_used[free_slot] = 1'b1;
                            slot_ip[free_slot]   = it.ip;
                            slot_port[free_slot] = it.port;
                            slot_id[free_slot]   = it.msg_id;
                        end
                        else
                            r.full = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.level   = level;
        r.waiting = link_busy;
        return r;
    endfunction

    // Random item: mostly well-formed traffic, some noise and near-miss acks
    function automatic link_item_t make_item();
        link_item_t it;
        int         r;
        int         k;
        int         b;
        it.cmd    = CMD_TICK;
        it.msg_id = $urandom;
        it.len    = LEN_W'($urandom_range(65535));
        it.ip     = $urandom;
        it.port   = PORT_W'($urandom_range(65535));
        r         = $urandom_range(99);
        if (r < 38)
            it.cmd = CMD_TICK;
        else if (r < 56)
            it.cmd = CMD_SUBMIT;
        else if (r < 68)
        begin
            it.cmd    = CMD_RECV;
            it.msg_id = sent_id;
            it.len    = ACK_LEN;
        end
        else if (r < 90)
        begin
            it.cmd  = CMD_RECV;
            k       = $urandom_range(NPOOL - 1);
            b       = $urandom_range(9);
            it.ip   = pool_ip[k];
            it.port = pool_port[k];
            if (b < 5)
            begin
                it.msg_id    = pool_next[k];
                pool_next[k] = pool_next[k] + ID_W'($urandom_range(3) + 1);
            end
            else if (b < 7)
                it.msg_id = pool_next[k] - 1'b1;
            else if (b == 7)
                it.msg_id = RESTART_ID;
            else if (b == 9)
                it.msg_id = '0;
        end
        else
        begin
            b = $urandom_range(2);
            if (b == 0)
                it.cmd = CMD_NONE;
            else if (b == 1)
            begin
                it.cmd    = CMD_RECV;
                it.msg_id = sent_id ^ (ID_W'(1) << $urandom_range(ID_W - 1));
                it.len    = ACK_LEN;
            end
            else
            begin
                it.cmd    = CMD_RECV;
                it.msg_id = sent_id;
                it.len    = ACK_LEN ^ (LEN_W'(1) << $urandom_range(LEN_W - 1));
            end
        end
        return it;
    endfunction

    task automatic add_row(link_item_t it, int reps, bit typed, link_result_t res);
        plan_row_t row;
        row.item  = it;
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        plan.insert(plan.size(), row);
    endtask

    // Offer one item, wait for the handshake, then record its expected result
    task automatic push_item(link_item_t it, bit typed, link_result_t typed_res);
        link_result_t want;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= it.cmd;
        req_if.msg_id     <= it.msg_id;
        req_if.pkt_length <= it.len;
        req_if.src_ip     <= it.ip;
        req_if.src_port   <= it.port;
        do
            @(posedge clk);
        while (!req_if.ready);
        want = predict_result(it);
        if (typed)
            want = typed_res;
        exp_q.insert(exp_q.size(), want);
        n_items++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(logic [CFG_DW-1:0] w, logic [CFG_DW-1:0] l);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_WAIT_LIMIT;
        cfg_data <= w;
        @(posedge clk);
        cfg_addr <= REG_LOST_LIMIT;
        cfg_data <= l;
        @(posedge clk);
        cfg_we   <= 1'b0;
        lim_wait = w;
        lim_lost = l;
    endtask

    // Result side: random stalls, plus one long hold-off
    always @(posedge clk)
        rsp_if.ready <= (!stall_rsp && $urandom_range(99) >= rx_idle_pct) ? 1'b1 : 1'b0;

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        stall_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_rsp <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        link_result_t got;
        link_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.action, rsp_if.out_id, rsp_if.dest_ip, rsp_if.dest_port,
                    rsp_if.deliver, rsp_if.link_level, rsp_if.ack_pending,
                    rsp_if.table_full};
            if (exp_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: action %0d id %h", got.action, got.id);
            end
            else
            begin
                want = exp_q.pop_front();
                n_checked++;
                if (want.action == ACT_RETRANSMIT)
                    n_retx++;
                if (want.level == LVL_LOST)
                    n_lost++;
                if (want.action == ACT_SEND_ACK && !want.deliver)
                    n_dup++;
                if (want.full)
                    n_overflow++;
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                    begin
                        $display("mismatch at result %0d (expected / actual):", n_checked);
                        $display("  action %0d/%0d id %h/%h dip %h/%h dport %h/%h",
                                 want.action, got.action, want.id, got.id,
                                 want.dip, got.dip, want.dport, got.dport);
                        $display("  deliver %b/%b level %0d/%0d waiting %b/%b full %b/%b",
                                 want.deliver, got.deliver, want.level, got.level,
                                 want.waiting, got.waiting, want.full, got.full);
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("tb_stop_and_wait_arq_link_core failed");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t  row;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_addr          = REG_WAIT_LIMIT;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_TICK;
        req_if.msg_id     = '0;
        req_if.pkt_length = '0;
        req_if.src_ip     = '0;
        req_if.src_port   = '0;

        // model reset state
        link_busy = 1'b0;
        sent_id   = '0;
        tick_cnt  = '0;
        retx_cnt  = '0;
        level     = LVL_NORMAL;
        fifo_head = 0;
        fifo_cnt  = 0;
        lim_wait  = WAIT_LIMIT_RST;
        lim_lost  = LOST_LIMIT_RST;
        for (int i = 0; i < NSLOT; i++)
            slot_used[i] = 1'b0;
        for (int k = 0; k < NPOOL; k++)
        begin
            pool_ip[k]   = $urandom;
            pool_port[k] = PORT_W'($urandom_range(65535));
            pool_next[k] = ID_W'(2);
        end
        // same address, different port
        pool_ip[1] = pool_ip[0];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 7;
        rx_idle_pct = 76;

        // Directed table at reset limits
        add_row('{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_NONE, 32'h0, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        // unknown command changes nothing
        add_row('{CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b1,
                '{ACT_NONE, 32'h0, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        // matching ack while nothing is awaited
        add_row('{CMD_RECV, 32'h0, ACK_LEN, 32'h0A00_0001, 16'h1234}, 1, 1'b1,
                '{ACT_ACK_MATCH, 32'h0, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        add_row('{CMD_SUBMIT, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_QUEUED, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        add_row('{CMD_SUBMIT, 32'h5A5A_A5A5, 16'h0, 32'h0, 16'h0}, 6, 1'b0, '0);
        add_row('{CMD_SUBMIT, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b0, '0);
        // FIFO full: id refused
        add_row('{CMD_SUBMIT, 32'h1234_5678, 16'h0, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_QUEUE_FULL, 32'h1234_5678, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        add_row('{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_SEND_NEW, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b1, 1'b0});
        // right id, wrong length: data from a new sender
        add_row('{CMD_RECV, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b1,
                '{ACT_SEND_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, LVL_NORMAL,
                  1'b1, 1'b0});
        // lower id is a duplicate, restart id passes
        add_row('{CMD_RECV, 32'h5, 16'h0, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b0, '0);
        add_row('{CMD_RECV, RESTART_ID, 16'h0, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b0, '0);
        add_row('{CMD_RECV, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b0, '0);
        add_row('{CMD_RECV, 32'hFFFF_FFFF, 16'd17, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b0, '0);
        // ack length but wrong id: data
        add_row('{CMD_RECV, 32'h1234, ACK_LEN, 32'h0, 16'h0}, 1, 1'b0, '0);
        // timeout: ten quiet ticks, the eleventh retransmits
        add_row('{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0}, 10, 1'b0, '0);
        add_row('{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_RETRANSMIT, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, LVL_WARNING, 1'b1, 1'b0});
        add_row('{CMD_RECV, 32'hFFFF_FFFF, ACK_LEN, 32'h0, 16'h0}, 1, 1'b1,
                '{ACT_ACK_MATCH, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, LVL_NORMAL, 1'b0, 1'b0});
        add_row('{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0}, 1, 1'b0, '0);

        foreach (plan[i])
        begin
            row = plan[i];
            repeat (row.reps) push_item(row.item, row.typed, row.res);
        end
        drain();

        // Random phases under changing limits and idle patterns
        for (int p = 0; p < NPHASE; p++)
        begin
            set_limits(WAIT_SET[p], LOST_SET[p]);
            if (p >= 2 && p < 4)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 7;
            end
            else if (p >= 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 1)
                hold_go = 1'b1;
            repeat (PHASE_ITEMS) push_item(make_item(), 1'b0, '0);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (exp_q.size() != 0)
            n_errors++;

        $display("run covered %0d items and %0d results over %0d limit settings",
                 n_items, n_checked, NPHASE + 1);
        $display("seen: %0d retransmits, %0d at level lost, %0d duplicates, %0d overflows",
                 n_retx, n_lost, n_dup, n_overflow);
        if (n_errors == 0)
            $display("tb_stop_and_wait_arq_link_core passed");
        else
            $display("tb_stop_and_wait_arq_link_core failed");
        $finish;
    end

endmodule

@@ stop_and_wait_arq_link_core.f @@
rtl/sawl_pkg.sv
rtl/sawl_in_if.sv
rtl/sawl_out_if.sv
rtl/sawl_ctrl.sv
rtl/sawl_dp.sv
rtl/stop_and_wait_arq_link_core.sv
dv/tb_stop_and_wait_arq_link_core.sv
